FILE: hdl/stereo_linear_resampler_assert.svh
// Assertion macros shared by the checkers of the resampler.
// Each macro expands to one labeled concurrent assertion that is clocked on
// the rising edge and switched off while the reset input is high.
`ifndef STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// Same-cycle implication.
`define SLR_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication.
`define SLR_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: hdl/slr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SEQ_W    = 32;
   localparam int PHASE_W  = 36;

   localparam int PHASE_FRAC_BITS_DEFAULT   = 32;
   localparam int MAX_OUT_PER_FRAME_DEFAULT = 8;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;

   // A step of exactly 1.0 with 32 fraction bits.
   localparam logic [PHASE_W-1:0] STEP_RESET = 36'h1_0000_0000;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   // One unit of work for the back end: the pair to interpolate and what
   // to do to the phase before the run starts.
   typedef struct packed {
      logic       mask_frac;
      logic       shift;
      sample_type cur_left;
      sample_type cur_right;
      sample_type nxt_left;
      sample_type nxt_right;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: hdl/stereo_linear_resampler.sv
// A frame that opens a run shows its first output frame on rsp_tvalid once it
// has passed the queue and the start, multiply and round steps.
// Throughput: one output frame per cycle while the sink is ready within a run;
// a queued source frame first takes a setup step, and another if it yields no output.
// Reset (synchronous, active high) empties the queue and pipeline, clears the
// pair and phase and sets the step to 1.0; a step write does the same, step from csr_data.
`timescale 1ns / 1ps
`default_nettype none

module stereo_linear_resampler #(
   parameter int PHASE_FRAC_BITS   = slr_pkg::PHASE_FRAC_BITS_DEFAULT,
   parameter int MAX_OUT_PER_FRAME = slr_pkg::MAX_OUT_PER_FRAME_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Source frames.
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // src_left [15:0], src_right [31:16], frame_seq [63:32]
   input  wire logic [63:0] req_tdata,
   // Output frames.
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // out_left [15:0], out_right [31:16]
   output logic [31:0]      rsp_tdata,
   // run_last: final output frame caused by one source frame
   output logic             rsp_tlast,
   // Step register write, phase_step in bits [35:0].
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [35:0] csr_data
);
   import slr_pkg::*;

   // The front end owns the sample pair and the sequence check. Each source
   // frame that makes a new pair becomes one job in a short queue. The back
   // end owns the phase: for each job it trims or steps the phase, then runs
   // the interpolator once per output frame, one multiply stage and one
   // rounding stage, into the output register that faces the sink.

   logic             clear;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          pop_job;
   queue_status_type q_status;

   // A step write is always taken; it must only be issued while the block is idle, which the block does not enforce.
   assign csr_ready = 1'b1;
   assign clear     = csr_valid;

   slr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .q_status   (q_status),
      .push       (push),
      .job        (push_job)
   );

   slr_job_fifo u_queue (
      .clock    (clock),
      .reset    (reset),
      .clear    (clear),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .q_status (q_status)
   );

   slr_back #(
      .PHASE_FRAC_BITS   (PHASE_FRAC_BITS),
      .MAX_OUT_PER_FRAME (MAX_OUT_PER_FRAME)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .clear      (clear),
      .step_data  (csr_data),
      .q_status   (q_status),
      .job        (pop_job),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: hdl/slr_front.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // src_left [15:0], src_right [31:16], frame_seq [63:32]
   input  wire logic [63:0]               req_tdata,
   input  wire slr_pkg::queue_status_type q_status,
   output logic                           push,
   output slr_pkg::job_type               job
);
   import slr_pkg::*;

   sample_type       in_left;
   sample_type       in_right;
   logic [SEQ_W-1:0] in_seq;
   logic             accept;
   logic             gap;

   sample_type       cur_left_ff, cur_left_in;
   sample_type       cur_right_ff, cur_right_in;
   sample_type       nxt_left_ff, nxt_left_in;
   sample_type       nxt_right_ff, nxt_right_in;
   logic             have_cur_ff, have_cur_in;
   logic             have_nxt_ff, have_nxt_in;
   logic             pend_mask_ff, pend_mask_in;
   logic [SEQ_W-1:0] prev_seq_ff, prev_seq_in;

   assign in_left    = req_tdata[15:0];
   assign in_right   = req_tdata[31:16];
   assign in_seq     = req_tdata[63:32];
   assign req_tready = ~q_status.full;
   assign accept     = req_tvalid & req_tready;

   // A break in the numbering voids the pair; the phase fraction is trimmed
   // by the back end when the next job reaches it.
   assign gap = have_cur_ff && (in_seq != (prev_seq_ff + 32'd1));

   always_comb begin
      cur_left_in   = cur_left_ff;
      cur_right_in  = cur_right_ff;
      nxt_left_in   = nxt_left_ff;
      nxt_right_in  = nxt_right_ff;
      have_cur_in   = have_cur_ff;
      have_nxt_in   = have_nxt_ff;
      pend_mask_in  = pend_mask_ff;
      prev_seq_in   = prev_seq_ff;
      push          = 1'b0;
      job.mask_frac = pend_mask_ff;
      job.shift     = 1'b0;
      job.cur_left  = cur_left_ff;
      job.cur_right = cur_right_ff;
      job.nxt_left  = in_left;
      job.nxt_right = in_right;
      if (accept) begin
         prev_seq_in = in_seq;
         if (!have_cur_ff || gap) begin
            cur_left_in  = in_left;
            cur_right_in = in_right;
            have_cur_in  = 1'b1;
            have_nxt_in  = 1'b0;
            pend_mask_in = pend_mask_ff | gap;
         end else if (!have_nxt_ff) begin
            nxt_left_in  = in_left;
            nxt_right_in = in_right;
            have_nxt_in  = 1'b1;
            pend_mask_in = 1'b0;
            push         = 1'b1;
         end else begin
            cur_left_in   = nxt_left_ff;
            cur_right_in  = nxt_right_ff;
            nxt_left_in   = in_left;
            nxt_right_in  = in_right;
            pend_mask_in  = 1'b0;
            push          = 1'b1;
            job.shift     = 1'b1;
            job.cur_left  = nxt_left_ff;
            job.cur_right = nxt_right_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         have_cur_ff  <= 1'b0;
         have_nxt_ff  <= 1'b0;
         pend_mask_ff <= 1'b0;
         prev_seq_ff  <= '0;
      end else begin
         have_cur_ff  <= have_cur_in;
         have_nxt_ff  <= have_nxt_in;
         pend_mask_ff <= pend_mask_in;
         prev_seq_ff  <= prev_seq_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_left_ff  <= cur_left_in;
      cur_right_ff <= cur_right_in;
      nxt_left_ff  <= nxt_left_in;
      nxt_right_ff <= nxt_right_in;
   end

endmodule

`default_nettype wire

FILE: hdl/slr_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_job_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              clear,
   input  wire logic              push,
   input  wire slr_pkg::job_type  push_job,
   input  wire logic              pop,
   output slr_pkg::job_type       pop_job,
   output slr_pkg::queue_status_type q_status
);
   import slr_pkg::*;

   job_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_status.full  = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push & ~q_status.full;
   assign do_pop  = pop & ~q_status.empty;
   assign pop_job = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/slr_back.sv
`timescale 1ns / 1ps
`default_nettype none

module slr_back #(
   parameter int PHASE_FRAC_BITS   = slr_pkg::PHASE_FRAC_BITS_DEFAULT,
   parameter int MAX_OUT_PER_FRAME = slr_pkg::MAX_OUT_PER_FRAME_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      clear,
   input  wire logic [35:0]               step_data,
   input  wire slr_pkg::queue_status_type q_status,
   input  wire slr_pkg::job_type          job,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // out_left [15:0], out_right [31:16]
   output logic [31:0]                    rsp_tdata,
   output logic                           rsp_tlast
);
   import slr_pkg::*;

   localparam int PROD_W = PHASE_FRAC_BITS + SAMPLE_W + 2;
   localparam int CNT_W  = (MAX_OUT_PER_FRAME > 1) ? $clog2(MAX_OUT_PER_FRAME) : 1;
   localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC_BITS;
   localparam logic [PHASE_W-1:0] FRAC_MASK  = PHASE_ONE - PHASE_W'(1);
   localparam logic [PHASE_W-1:0] PHASE_MAX  = '1;
   localparam logic [CNT_W-1:0]   CNT_LAST   = CNT_W'(MAX_OUT_PER_FRAME - 1);
   localparam logic signed [PROD_W-1:0] RND_POS = PROD_W'(1) << (PHASE_FRAC_BITS - 1);
   localparam logic signed [PROD_W-1:0] RND_NEG = RND_POS - PROD_W'(1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic                       state_ff, state_in;
   logic [PHASE_W-1:0]         step_ff;
   logic [PHASE_W-1:0]         phase_ff, phase_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   sample_type                 cur_l_ff, cur_r_ff;
   logic signed [SAMPLE_W:0]   dif_l_ff, dif_r_ff;

   logic [PHASE_W-1:0]         phase_masked;
   logic [PHASE_W-1:0]         phase_start;
   logic [PHASE_W:0]           phase_sum;
   logic [PHASE_W-1:0]         phase_sat;
   logic                       below_one;
   logic                       last;
   logic                       issue;
   logic signed [PHASE_FRAC_BITS:0] frac_s;

   logic                       m_vld_ff;
   logic signed [PROD_W-1:0]   prod_l_ff, prod_l_in;
   logic signed [PROD_W-1:0]   prod_r_ff, prod_r_in;
   sample_type                 mcur_l_ff, mcur_r_ff;
   logic                       mlast_ff;
   logic                       m_free;
   logic                       o_load;

   logic signed [PROD_W-1:0]   v_l, v_r;
   logic signed [PROD_W-1:0]   r_l, r_r;
   logic                       o_vld_ff;
   sample_type                 out_l_ff, out_r_ff;
   logic                       out_last_ff;

   // Phase as the job finds it: gap trims to the fraction, a shift steps
   // one source frame forward and stops at zero.
   always_comb begin
      phase_masked = job.mask_frac ? (phase_ff & FRAC_MASK) : phase_ff;
      if (!job.shift) begin
         phase_start = phase_masked;
      end else if (phase_masked >= PHASE_ONE) begin
         phase_start = phase_masked - PHASE_ONE;
      end else begin
         phase_start = '0;
      end
   end

   assign phase_sum = {1'b0, phase_ff} + {1'b0, step_ff};
   assign phase_sat = phase_sum[PHASE_W] ? PHASE_MAX : phase_sum[PHASE_W-1:0];
   assign below_one = (phase_ff < PHASE_ONE);
   assign last      = (phase_sat >= PHASE_ONE) || (cnt_ff == CNT_LAST);
   assign frac_s    = $signed({1'b0, phase_ff[PHASE_FRAC_BITS-1:0]});

   assign o_load = m_vld_ff & (~o_vld_ff | rsp_tready);
   assign m_free = ~m_vld_ff | o_load;
   assign pop    = (state_ff == S_IDLE) & ~q_status.empty;
   assign issue  = (state_ff == S_RUN) & below_one & m_free;

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               phase_in = phase_start;
               cnt_in   = '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (!below_one) begin
               state_in = S_IDLE;
            end else if (issue) begin
               phase_in = phase_sat;
               cnt_in   = cnt_ff + 1'b1;
               if (last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_RESET;
      end else if (clear) begin
         step_ff <= step_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         cnt_ff   <= '0;
         m_vld_ff <= 1'b0;
         o_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         if (issue) begin
            m_vld_ff <= 1'b1;
         end else if (o_load) begin
            m_vld_ff <= 1'b0;
         end
         if (o_load) begin
            o_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            o_vld_ff <= 1'b0;
         end
      end
   end

   // Multiply stage: (nxt - cur) * fraction for both channels.
   always_comb begin
      prod_l_in = dif_l_ff * frac_s;
      prod_r_in = dif_r_ff * frac_s;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_l_ff <= job.cur_left;
         cur_r_ff <= job.cur_right;
         dif_l_ff <= (SAMPLE_W + 1)'(job.nxt_left) - (SAMPLE_W + 1)'(job.cur_left);
         dif_r_ff <= (SAMPLE_W + 1)'(job.nxt_right) - (SAMPLE_W + 1)'(job.cur_right);
      end
      if (issue) begin
         prod_l_ff <= prod_l_in;
         prod_r_ff <= prod_r_in;
         mcur_l_ff <= cur_l_ff;
         mcur_r_ff <= cur_r_ff;
         mlast_ff  <= last;
      end
   end

   // Rounding stage: half away from zero is floor((v + h) / 2^F) for v >= 0
   // and floor((v + h - 1) / 2^F) for v < 0.
   always_comb begin
      v_l = (PROD_W'(mcur_l_ff) <<< PHASE_FRAC_BITS) + prod_l_ff;
      v_r = (PROD_W'(mcur_r_ff) <<< PHASE_FRAC_BITS) + prod_r_ff;
      r_l = (v_l + (v_l[PROD_W-1] ? RND_NEG : RND_POS)) >>> PHASE_FRAC_BITS;
      r_r = (v_r + (v_r[PROD_W-1] ? RND_NEG : RND_POS)) >>> PHASE_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (o_load) begin
         out_l_ff    <= r_l[SAMPLE_W-1:0];
         out_r_ff    <= r_r[SAMPLE_W-1:0];
         out_last_ff <= mlast_ff;
      end
   end

   assign rsp_tvalid = o_vld_ff;
   assign rsp_tdata  = {out_r_ff, out_l_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

`default_nettype wire

FILE: hdl/slr_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "stereo_linear_resampler_assert.svh"

module slr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic [63:0] req_tdata,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        csr_valid,
   input wire logic        csr_ready,
   input wire logic [35:0] csr_data
);

   // A stalled output beat holds until taken or a step write flushes it.
   `SLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready && !csr_valid, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "output beat changed while stalled")

   // Nothing is offered right after reset.
   `SLR_ASSERT_NOW(a_rsp_after_reset, clock, reset, $past(reset), !rsp_tvalid, "output valid right after reset")

   // A step write empties the pipeline.
   `SLR_ASSERT_NEXT(a_clear_flush, clock, reset, csr_valid && csr_ready, !rsp_tvalid, "output valid after step write")

   // The frame after a step write only primes the pair, so no output follows
   // the flush either.
   `SLR_ASSERT_NOW(a_clear_prime, clock, reset, $past(csr_valid, 2) && !$past(reset), !rsp_tvalid, "output too soon after step write")

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (.*);

`default_nettype wire

FILE: tb/stereo_linear_resampler_tb.sv
`timescale 1ns / 1ps

// One output frame as the block should present it.
typedef struct {
   slr_pkg::sample_type left;
   slr_pkg::sample_type right;
   logic                last;
} out_frame_type;

// Tracks the resampler state alongside the block and holds the output frames
// still owed, oldest first.
class interp_tracker;
   localparam logic [35:0] PHASE_ONE = 36'h1_0000_0000;
   localparam int          RUN_CAP   = 8;

   logic [35:0]         step;
   logic [35:0]         acc;
   slr_pkg::sample_type cur_l, cur_r, nxt_l, nxt_r;
   logic                have_cur, have_nxt;
   logic [31:0]         last_seq;
   out_frame_type       owed[$];
   int unsigned         faults;

   function new();
      step   = slr_pkg::STEP_RESET;
      faults = 0;
      clear();
   endfunction

   function void clear();
      acc      = '0;
      cur_l    = '0;
      cur_r    = '0;
      nxt_l    = '0;
      nxt_r    = '0;
      have_cur = 1'b0;
      have_nxt = 1'b0;
      last_seq = '0;
   endfunction

   function void set_step(logic [35:0] value);
      step = value;
      clear();
   endfunction

   function int pending();
      return owed.size();
   endfunction

   // a + (b - a) * frac, rounded to nearest with ties away from zero.
   function automatic slr_pkg::sample_type lerp(slr_pkg::sample_type a,
                                                slr_pkg::sample_type b,
                                                logic [31:0] frac);
      longint v;
      longint mag;
      longint half;
      half = 64'h8000_0000;
      v = longint'(a) * 64'h1_0000_0000
          + (longint'(b) - longint'(a)) * longint'({32'b0, frac});
      if (v >= 0) begin
         mag = (v + half) >>> 32;
      end else begin
         mag = -((-v + half) >>> 32);
      end
      return mag[15:0];
   endfunction

   function void take_source(slr_pkg::sample_type l, slr_pkg::sample_type r,
                             logic [31:0] seq);
      int            n;
      logic [36:0]   sum;
      logic [35:0]   next_acc;
      out_frame_type f;
      n = 0;
      if (have_cur && seq != last_seq + 32'd1) begin
         acc      = {4'b0, acc[31:0]};
         have_cur = 1'b0;
         have_nxt = 1'b0;
      end
      last_seq = seq;
      if (!have_cur) begin
         cur_l    = l;
         cur_r    = r;
         have_cur = 1'b1;
         return;
      end
      if (!have_nxt) begin
         nxt_l    = l;
         nxt_r    = r;
         have_nxt = 1'b1;
      end else begin
         acc   = (acc >= PHASE_ONE) ? acc - PHASE_ONE : '0;
         cur_l = nxt_l;
         cur_r = nxt_r;
         nxt_l = l;
         nxt_r = r;
      end
      while (acc < PHASE_ONE && n < RUN_CAP) begin
         f.left   = lerp(cur_l, nxt_l, acc[31:0]);
         f.right  = lerp(cur_r, nxt_r, acc[31:0]);
         sum      = {1'b0, acc} + {1'b0, step};
         next_acc = sum[36] ? '1 : sum[35:0];
         n++;
         f.last   = (n == RUN_CAP) || (next_acc >= PHASE_ONE);
         owed.push_back(f);
         acc      = next_acc;
      end
   endfunction

   function void match_output(slr_pkg::sample_type l, slr_pkg::sample_type r,
                              logic last);
      out_frame_type f;
      if (owed.size() == 0) begin
         $error("output frame with none owed: left %0d right %0d last %0b", l, r, last);
         faults++;
         return;
      end
      f = owed.pop_front();
      if (l !== f.left) begin
         $error("out_left: expected %0d, actual %0d", f.left, l);
         faults++;
      end
      if (r !== f.right) begin
         $error("out_right: expected %0d, actual %0d", f.right, r);
         faults++;
      end
      if (last !== f.last) begin
         $error("run_last: expected %0b, actual %0b", f.last, last);
         faults++;
      end
   endfunction
endclass

module stereo_linear_resampler_tb;
   import slr_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [35:0] csr_data = '0;

   // While calm is set neither side of the stream ever idles.
   bit          calm = 1'b0;
   logic [31:0] seq_now;
   int          random_items;
   int          phase_len;
   logic [35:0] step_pick;

   interp_tracker tracker = new();

   stereo_linear_resampler u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The sink stalls in roughly one cycle of five unless the run is calm.
   // Ready changes only at the falling edge, so the rising edge sees it stable.
   always @(negedge clock) begin
      rsp_tready = calm ? 1'b1 : ($urandom_range(0, 99) >= 19);
   end

   // Every output beat is checked against the oldest owed frame.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         tracker.match_output(rsp_tdata[15:0], rsp_tdata[31:16], rsp_tlast);
      end
   end

   // Hands one source frame to the block. The task starts and ends at a
   // falling edge; valid stays high from one beat to the next unless an idle
   // cycle is drawn in between.
   task automatic send_frame(sample_type l, sample_type r, logic [31:0] seq);
      while (!calm && $urandom_range(0, 99) < 19) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = {seq, r, l};
      do @(posedge clock); while (!req_tready);
      tracker.take_source(l, r, seq);
      @(negedge clock);
   endtask

   // The step register is only written once the block has drained. A frame
   // that yields no output may still be in the queue when the last owed
   // output has left, so the task also waits out the pipeline before it writes.
   task automatic write_step(logic [35:0] value);
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      tracker.set_step(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   // Mostly consecutive sequence numbers; now and then a gap, a repeat or a
   // jump to anywhere.
   function automatic logic [31:0] next_seq(logic [31:0] prev);
      case ($urandom_range(0, 39))
         0:       return $urandom;
         1:       return prev;
         2:       return prev + 32'd2 + $urandom_range(0, 5);
         default: return prev + 32'd1;
      endcase
   endfunction

   function automatic logic [35:0] pick_step();
      logic [35:0] s;
      case ($urandom_range(0, 7))
         0: s = 36'h0_2000_0000;
         1: s = 36'h8_0000_0000;
         2, 3, 4: s = {4'($urandom_range(0, 1)), $urandom};
         default: s = {4'($urandom_range(0, 7)), $urandom};
      endcase
      if (s < 36'h0_2000_0000) s = s + 36'h0_2000_0000;
      return s;
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Step of one after reset: priming yields nothing, then one output per
      // frame at phase zero. Full-scale samples, a sequence wrap and a gap
      // that restarts priming.
      send_frame(16'sh7fff, 16'sh8000, 32'hffff_fffe);
      send_frame(16'sh8000, 16'sh7fff, 32'hffff_ffff);
      send_frame(16'sh0000, 16'sh0000, 32'h0000_0000);
      send_frame(16'sh0001, -16'sh0001, 32'h0000_0001);
      send_frame(16'sh1234, 16'sh4321, 32'h0000_0009);
      send_frame(-16'sh1234, 16'sh0fff, 32'h0000_000a);

      // Half step: ties at one half round away from zero, and a gap keeps the
      // phase fraction.
      write_step(36'h0_8000_0000);
      send_frame(16'sh0000, 16'sh0000, 32'h5555_aaaa);
      send_frame(16'sh0001, -16'sh0001, 32'h5555_aaab);
      send_frame(16'sh7fff, 16'sh8000, 32'h5555_aaac);
      send_frame(16'sh8000, 16'sh7fff, 32'h5555_aaad);
      send_frame(16'sh0003, 16'sh0005, 32'haaaa_5555);
      send_frame(16'sh0004, 16'sh0002, 32'haaaa_5556);

      // Largest legal step: most frames only shift the pair.
      write_step(36'h8_0000_0000);
      for (int i = 0; i < 10; i++) begin
         send_frame(16'(i * 1000), 16'(-i * 999), 32'h0000_0100 + i);
      end

      // A zero step gives a capped run; the next frame gives another, as the phase stays at zero.
      write_step(36'h0_0000_0000);
      send_frame(16'sh0100, 16'sh0200, 32'h0000_0000);
      send_frame(16'sh0300, 16'sh0400, 32'h0000_0001);
      send_frame(16'sh0500, 16'sh0600, 32'h0000_0002);

      // An all-ones step takes the phase to its ceiling.
      write_step(36'hf_ffff_ffff);
      send_frame(16'sh0010, 16'sh0020, 32'h0000_0007);
      send_frame(16'sh0030, 16'sh0040, 32'h0000_0008);
      send_frame(16'sh0050, 16'sh0060, 32'h0000_0009);

      // Smallest legal step: eight outputs per frame.
      write_step(36'h0_2000_0000);
      send_frame(16'sh7fff, 16'sh8000, 32'h0000_0000);
      send_frame(16'sh8000, 16'sh7fff, 32'h0000_0001);
      send_frame(16'sh0000, -16'sh0001, 32'h0000_0002);

      // Random phases, each with its own step and a random starting sequence
      // number. The second phase runs without any idling.
      random_items = 0;
      for (int p = 0; random_items < 175; p++) begin
         step_pick = pick_step();
         write_step(step_pick);
         calm      = (p == 1);
         phase_len = $urandom_range(18, 36);
         seq_now   = $urandom;
         for (int i = 0; i < phase_len; i++) begin
            send_frame(pick_sample(), pick_sample(), seq_now);
            seq_now = next_seq(seq_now);
         end
         calm = 1'b0;
         random_items += phase_len;
      end

      // Drain, then give the block time to show any output that is not owed.
      req_tvalid = 1'b0;
      while (tracker.pending() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (tracker.faults == 0 && tracker.pending() == 0) begin
         $display("stereo_linear_resampler_tb: clean");
      end else begin
         $display("stereo_linear_resampler_tb: errors");
      end
      $finish;
   end

   // A correct run needs well under a tenth of this time.
   initial begin
      #5_000_000;
      $display("stereo_linear_resampler_tb: errors");
      $finish;
   end

endmodule
